>>> rtl/core/spjq_pkg.sv
// Package with the shared types and codes of the sorted priority job queue.
`timescale 1ns / 1ps

package spjq_pkg;

  // Default number of job slots in the queue.
  localparam int unsigned SpjqDepth = 8;

  // Field widths of the channels.
  localparam int unsigned CmdW    = 2;
  localparam int unsigned IdW     = 16;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 4;

  // Command codes of an input beat.
  typedef enum logic [CmdW-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_LIST    = 2'd2,
    CMD_NONE    = 2'd3
  } spjq_cmd_e;

  // Status codes of a result beat.
  typedef enum logic [StatusW-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_RSVD  = 2'd3
  } spjq_status_e;

  // One stored job.
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } job_t;

  // Operation that every cell of the chain performs in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_ROTATE = 2'd3
  } spjq_op_e;

  // Control broadcast from the sequencer to all cells.
  typedef struct packed {
    spjq_op_e op;
    job_t     new_job;
  } cell_ctrl_t;

endpackage

>>> rtl/core/spjq_if.sv
// Valid/ready channel interfaces for the job queue's input and result beats.
`timescale 1ns / 1ps

interface spjq_in_if;
  logic                     valid;
  logic                     ready;
  logic [spjq_pkg::CmdW-1:0]  command;
  logic [spjq_pkg::IdW-1:0]   job_id;
  logic [spjq_pkg::PrioW-1:0] job_priority;

  modport source (output valid, output command, output job_id, output job_priority,
                  input ready);
  modport sink (input valid, input command, input job_id, input job_priority,
                output ready);
endinterface

interface spjq_out_if;
  logic                        valid;
  logic                        ready;
  logic [spjq_pkg::StatusW-1:0] status;
  logic [spjq_pkg::IdW-1:0]     out_id;
  logic [spjq_pkg::PrioW-1:0]   out_priority;
  logic                        entry_valid;
  logic                        last;
  logic [spjq_pkg::OccW-1:0]    occupancy;

  modport source (output valid, output status, output out_id, output out_priority,
                  output entry_valid, output last, output occupancy, input ready);
  modport sink (input valid, input status, input out_id, input out_priority,
                input entry_valid, input last, input occupancy, output ready);
endinterface

>>> rtl/core/spjq_cell.sv
// One slot of the sorted job chain; trades jobs with its two neighbors.
`timescale 1ns / 1ps

module spjq_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spjq_pkg::cell_ctrl_t ctrl_i,
  input  spjq_pkg::job_t       head_job_i,
  input  logic                 left_valid_i,
  input  spjq_pkg::job_t       left_job_i,
  input  logic                 left_greater_i,
  input  logic                 right_valid_i,
  input  spjq_pkg::job_t       right_job_i,
  output logic                 valid_o,
  output spjq_pkg::job_t       job_o,
  output logic                 greater_o
);
  import spjq_pkg::*;

  logic valid_q, valid_d;
  job_t job_q, job_d;

  // A stored job that must step back to make room for the new one.
  assign greater_o = valid_q && (job_q.prio > ctrl_i.new_job.prio);

  // Next contents of the slot.
  always_comb begin
    valid_d = valid_q;
    job_d   = job_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (left_greater_i) begin
          // The left neighbor's job moves back into this slot.
          valid_d = left_valid_i;
          job_d   = left_job_i;
        end else if ((!valid_q || greater_o) && left_valid_i) begin
          // This slot is the insertion point: the first free or greater slot
          // right behind an occupied slot that keeps its job.
          valid_d = 1'b1;
          job_d   = ctrl_i.new_job;
        end
      end
      OP_SHIFT: begin
        valid_d = right_valid_i;
        job_d   = right_job_i;
      end
      OP_ROTATE: begin
        // Walk the stored jobs toward the head; the tail slot takes the head.
        if (right_valid_i) begin
          job_d = right_job_i;
        end else if (valid_q) begin
          job_d = head_job_i;
        end
      end
      default: begin
      end
    endcase
  end

  // Occupancy flag is control state; the job itself needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign valid_o = valid_q;
  assign job_o   = job_q;

endmodule

>>> rtl/core/spjq_chain.sv
// Row of job cells kept sorted by ascending priority, head at cell 0.
`timescale 1ns / 1ps

module spjq_chain #(
  parameter int unsigned DEPTH = spjq_pkg::SpjqDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spjq_pkg::cell_ctrl_t ctrl_i,
  output spjq_pkg::job_t       head_job_o,
  output logic [DEPTH-1:0]     valid_o
);
  import spjq_pkg::*;

  logic [DEPTH-1:0] cell_valid;
  logic [DEPTH-1:0] cell_greater;
  job_t             cell_job [DEPTH];

  // Each cell sees its left and right neighbors. The head end looks like an
  // occupied slot whose job never steps back; the tail end sees an empty slot.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic l_valid, l_greater, r_valid;
    job_t l_job, r_job;

    if (g == 0) begin : g_left_end
      assign l_valid   = 1'b1;
      assign l_greater = 1'b0;
      assign l_job     = '0;
    end else begin : g_left
      assign l_valid   = cell_valid[g-1];
      assign l_greater = cell_greater[g-1];
      assign l_job     = cell_job[g-1];
    end

    if (g == DEPTH - 1) begin : g_right_end
      assign r_valid = 1'b0;
      assign r_job   = '0;
    end else begin : g_right
      assign r_valid = cell_valid[g+1];
      assign r_job   = cell_job[g+1];
    end

    spjq_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl_i),
      .head_job_i     (cell_job[0]),
      .left_valid_i   (l_valid),
      .left_job_i     (l_job),
      .left_greater_i (l_greater),
      .right_valid_i  (r_valid),
      .right_job_i    (r_job),
      .valid_o        (cell_valid[g]),
      .job_o          (cell_job[g]),
      .greater_o      (cell_greater[g])
    );
  end

  assign head_job_o = cell_job[0];
  assign valid_o    = cell_valid;

endmodule

>>> rtl/core/sorted_priority_job_queue_unit.sv
// Top level of the sorted priority job queue: sequencer, result register, cell chain.
`timescale 1ns / 1ps
//
// Use: input beats on in_i carry a command (enqueue, dequeue, list) with a
// job id and priority; result beats on out_o carry a status, an optional
// job, a last flag and the queue occupancy after the operation.
// Jobs live in a chain of DEPTH cells kept sorted by priority, smaller first,
// equal priorities in arrival order.
// For an enqueue or dequeue that succeeds, the chain moves every job in the
// cycle that the input beat is taken; the single result appears in the output
// register in the next cycle. With the receiver ready, one such command is
// taken every cycle. A list of N stored jobs gives N result beats, on
// consecutive cycles while the receiver is ready; the chain rotates by one
// cell per beat, so the input is not ready until the last beat has been
// produced, and the order is restored when the last beat is sent.
// Command 3 gives no result and changes nothing.
// When the receiver stalls, the result register holds its beat and the input
// waits; a new command enters in the cycle that the held beat is taken.
// Reset empties the queue and drops any pending result; no clearing pass runs.
//
module sorted_priority_job_queue_unit #(
  parameter int unsigned DEPTH = spjq_pkg::SpjqDepth
) (
  input logic        clk_i,
  input logic        rst_ni,
  spjq_in_if.sink    in_i,
  spjq_out_if.source out_o
);
  import spjq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  list_left_q, list_left_d;
  logic             out_valid_q, out_valid_d;
  spjq_status_e     status_q, status_d;
  job_t             out_job_q, out_job_d;
  logic             entry_valid_q, entry_valid_d;
  logic             last_q, last_d;

  cell_ctrl_t       ctrl;
  job_t             head_job;
  logic [DEPTH-1:0] cell_valid;
  logic             slot_free;
  logic             in_acc;
  spjq_cmd_e        cmd;

  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && slot_free;
  assign in_acc = in_i.valid && in_i.ready;
  assign cmd = spjq_cmd_e'(in_i.command);

  spjq_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .head_job_o (head_job),
    .valid_o    (cell_valid)
  );

  // Sequencer: decode the command, steer the chain, build the result beat.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    list_left_d   = list_left_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    status_d      = status_q;
    out_job_d     = out_job_q;
    entry_valid_d = entry_valid_q;
    last_d        = last_q;
    ctrl.op       = OP_HOLD;
    ctrl.new_job  = '{id: in_i.job_id, prio: in_i.job_priority};

    case (state_q)
      ST_IDLE: begin
        if (in_acc && cmd != CMD_NONE) begin
          out_valid_d   = 1'b1;
          status_d      = STATUS_DONE;
          out_job_d     = '0;
          entry_valid_d = 1'b0;
          last_d        = 1'b1;
          case (cmd)
            CMD_ENQUEUE: begin
              if (count_q == CntW'(DEPTH)) begin
                status_d = STATUS_FULL;
              end else begin
                ctrl.op = OP_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            CMD_DEQUEUE: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else begin
                ctrl.op       = OP_SHIFT;
                count_d       = count_q - 1'b1;
                out_job_d     = head_job;
                entry_valid_d = 1'b1;
              end
            end
            CMD_LIST: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else begin
                ctrl.op       = OP_ROTATE;
                out_job_d     = head_job;
                entry_valid_d = 1'b1;
                last_d        = (count_q == CntW'(1));
                list_left_d   = count_q - 1'b1;
                if (count_q != CntW'(1)) begin
                  state_d = ST_LIST;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        // One stored job per beat, head first, rotating the chain behind it.
        if (slot_free) begin
          ctrl.op       = OP_ROTATE;
          out_valid_d   = 1'b1;
          status_d      = STATUS_DONE;
          out_job_d     = head_job;
          entry_valid_d = 1'b1;
          last_d        = (list_left_q == CntW'(1));
          list_left_d   = list_left_q - 1'b1;
          if (list_left_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, count and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      list_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      list_left_q <= list_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q      <= status_d;
    out_job_q     <= out_job_d;
    entry_valid_q <= entry_valid_d;
    last_q        <= last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.out_id       = out_job_q.id;
  assign out_o.out_priority = out_job_q.prio;
  assign out_o.entry_valid  = entry_valid_q;
  assign out_o.last         = last_q;
  assign out_o.occupancy    = OccW'(count_q);

`ifndef SYNTH
  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("job count exceeds queue depth");

  // The occupied cells always match the job count.
  a_cells_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("occupied cells disagree with job count");

  // Occupied cells form one block starting at the head.
  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("occupied cells are not packed at the head");

  // A held result beat is not overwritten.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_job_q) && $stable(last_q))
    else $error("stalled result beat changed");

  // A list in progress keeps the input closed.
  a_list_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST |-> !in_i.ready)
    else $error("input accepted during a list");
`endif

endmodule
